>>> hw/rtl/mscx_pkg.sv
// ----------------------------------------------------------------------------
// mscx_pkg
// shared constants and types of the structural character indexer
// ----------------------------------------------------------------------------
package mscx_pkg;

  localparam int CHUNK_BYTES = 16;
  localparam int BYTE_W      = 8;
  localparam int CHUNK_W     = CHUNK_BYTES * BYTE_W;
  localparam int IDX_W       = $clog2(CHUNK_BYTES);
  localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);
  localparam int SCAN_STEPS  = $clog2(CHUNK_BYTES);
  localparam int POS_W       = 32;
  localparam int HALF_W      = 64;
  localparam int COUNT_W     = 5;

  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

  // per byte class bits handed from a lane to the merge stage
  typedef struct packed {
    logic dq;
    logic sq;
    logic special;
  } mscx_cls_t;

endpackage

>>> hw/rtl/mscx_if.sv
// ----------------------------------------------------------------------------
// mscx_in_if / mscx_out_if
// valid/ready channels of the structural character indexer
// ----------------------------------------------------------------------------
interface mscx_in_if
  import mscx_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [HALF_W-1:0]   bytes_low;
  logic [HALF_W-1:0]   bytes_high;
  logic [COUNT_W-1:0]  byte_count;
  logic                buffer_start;

  modport source (output valid, bytes_low, bytes_high, byte_count, buffer_start,
                  input ready);
  modport sink   (input valid, bytes_low, bytes_high, byte_count, buffer_start,
                  output ready);
  modport monitor (input valid, ready, bytes_low, bytes_high, byte_count,
                   buffer_start);
endinterface

interface mscx_out_if
  import mscx_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   position;
  logic [BYTE_W-1:0]  character;
  logic               last_of_chunk;

  modport source (output valid, position, character, last_of_chunk, input ready);
  modport sink   (input valid, position, character, last_of_chunk, output ready);
  modport monitor (input valid, ready, position, character, last_of_chunk);
endinterface

>>> hw/rtl/mscx_lane.sv
// ----------------------------------------------------------------------------
// mscx_lane
// classifies one chunk byte as quote or markup special
// ----------------------------------------------------------------------------
module mscx_lane
  import mscx_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_in,
  output mscx_cls_t         cls
);

  always_comb begin
    cls.dq      = (byte_in == CH_DQUOTE);
    cls.sq      = (byte_in == CH_SQUOTE);
    cls.special = (byte_in == CH_LT) || (byte_in == CH_GT) || (byte_in == CH_SLASH) ||
                  (byte_in == CH_EQ) || (byte_in == CH_AMP);
  end

endmodule

>>> hw/rtl/mscx_merge.sv
// ----------------------------------------------------------------------------
// mscx_merge
// prefix xor of quote parities over the lanes and the emit mask
// ----------------------------------------------------------------------------
module mscx_merge
  import mscx_pkg::*;
(
  input  mscx_cls_t [CHUNK_BYTES-1:0] cls,
  input  logic [CNT_W-1:0]            count,
  input  logic                        dq_in,
  input  logic                        sq_in,
  output logic [CHUNK_BYTES-1:0]      emit_mask,
  output logic                        dq_out,
  output logic                        sq_out
);

  logic [CHUNK_BYTES-1:0] vmask;
  logic [CHUNK_BYTES-1:0] dq_scan;
  logic [CHUNK_BYTES-1:0] sq_scan;

  // log-step inclusive xor scan, invalid bytes masked out
  always_comb begin
    logic [CHUNK_BYTES-1:0] dq_tmp;
    logic [CHUNK_BYTES-1:0] sq_tmp;
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      vmask[k]   = (CNT_W'(k) < count);
      dq_scan[k] = cls[k].dq & vmask[k];
      sq_scan[k] = cls[k].sq & vmask[k];
    end
    for (int j = 0; j < SCAN_STEPS; j++) begin
      dq_tmp = dq_scan;
      sq_tmp = sq_scan;
      for (int k = 0; k < CHUNK_BYTES; k++) begin
        if (k >= (1 << j)) begin
          dq_scan[k] = dq_tmp[k] ^ dq_tmp[k - (1 << j)];
          sq_scan[k] = sq_tmp[k] ^ sq_tmp[k - (1 << j)];
        end
      end
    end
  end

  always_comb begin
    logic ins_dq;
    logic ins_sq;
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      ins_dq       = dq_in ^ dq_scan[k];
      ins_sq       = sq_in ^ sq_scan[k];
      emit_mask[k] = vmask[k] &
                     (cls[k].dq | cls[k].sq | (cls[k].special & ~ins_dq & ~ins_sq));
    end
    // invalid bytes are masked, so the top bit is the parity at the last valid byte
    dq_out = dq_in ^ dq_scan[CHUNK_BYTES-1];
    sq_out = sq_in ^ sq_scan[CHUNK_BYTES-1];
  end

endmodule

>>> hw/rtl/mscx_emit.sv
// ----------------------------------------------------------------------------
// mscx_emit
// serial emitter: one structural byte per cycle unless the output stalls, lowest position first
// ----------------------------------------------------------------------------
module mscx_emit
  import mscx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [CHUNK_BYTES-1:0] mask_in,
  input  logic [CHUNK_W-1:0]     bytes_in,
  input  logic [POS_W-1:0]       base_in,
  output logic                   can_load,
  mscx_out_if.source             out_ch
);

  logic [CHUNK_BYTES-1:0] pend_r, pend_nxt;
  logic [CHUNK_W-1:0]     bytes_r;
  logic [POS_W-1:0]       base_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]       out_pos_r;
  logic [BYTE_W-1:0]      out_char_r;
  logic                   out_last_r;

  logic [CHUNK_BYTES-1:0] pend_clr;
  logic [CHUNK_BYTES-1:0] pick_oh;
  logic [IDX_W-1:0]       pick_idx;
  logic                   adv;

  assign pick_oh  = pend_r & (~pend_r + 1'b1);
  assign pend_clr = pend_r & (pend_r - 1'b1);
  assign adv      = (|pend_r) & (~out_valid_r | out_ch.ready);
  // free when nothing is pending or the last pick moves out this cycle
  assign can_load = ~(|pend_r) | (adv & ~(|pend_clr));

  always_comb begin
    pick_idx = '0;
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      if (pick_oh[k]) begin
        pick_idx = pick_idx | IDX_W'(k);
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = mask_in;
    end else if (adv) begin
      pend_nxt = pend_clr;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= bytes_in;
      base_r  <= base_in;
    end
    if (adv) begin
      out_pos_r  <= base_r + POS_W'(pick_idx);
      out_char_r <= bytes_r[pick_idx*BYTE_W +: BYTE_W];
      out_last_r <= ~(|pend_clr);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.character     = out_char_r;
  assign out_ch.last_of_chunk = out_last_r;

endmodule

>>> hw/rtl/markup_structural_char_indexer.sv
// ----------------------------------------------------------------------------
// markup_structural_char_indexer
// finds < > / = & and both quote kinds in 16-byte chunks of markup text
//
//   channel  | dir | transfer carries
//   ---------+-----+-----------------------------------------------------
//   in_chan  | in  | bytes_low, bytes_high, byte_count, buffer_start
//   out_chan | out | position, character, last_of_chunk (one per hit)
//
// a chunk is classified combinationally by one lane per byte; the merge stage
// runs the quote parity scan and builds the emit mask, all at accept time.
// results leave one per cycle, unless the output stalls, from a single output
// register; a chunk with hits holds the input until the serial picker takes its last hit.
// reset (rst_n low, synchronous) clears parities, offset and pending hits.
// a stalled output holds its result; the next chunk is taken as the last
// hit of the current one moves into the output register.
// ----------------------------------------------------------------------------
module markup_structural_char_indexer
  import mscx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mscx_in_if.sink    in_chan,
  mscx_out_if.source out_chan
);

  // carried state between chunks
  logic             dq_r, dq_nxt;
  logic             sq_r, sq_nxt;
  logic [POS_W-1:0] offset_r, offset_nxt;

  // start flag clears state ahead of this chunk
  logic             dq_cur;
  logic             sq_cur;
  logic [POS_W-1:0] offset_cur;

  logic [2*HALF_W-1:0]          raw_bytes;
  logic [CHUNK_W-1:0]           chunk;
  logic [CNT_W-1:0]             count;
  mscx_cls_t [CHUNK_BYTES-1:0]  cls;
  logic [CHUNK_BYTES-1:0]       emit_mask;
  logic                         dq_end;
  logic                         sq_end;
  logic                         can_load;
  logic                         accept;

  assign raw_bytes = {in_chan.bytes_high, in_chan.bytes_low};
  assign chunk     = raw_bytes[CHUNK_W-1:0];

  // count saturates at the chunk size
  assign count = (in_chan.byte_count > COUNT_W'(CHUNK_BYTES)) ? CNT_W'(CHUNK_BYTES)
                                                              : CNT_W'(in_chan.byte_count);

  assign dq_cur     = in_chan.buffer_start ? 1'b0 : dq_r;
  assign sq_cur     = in_chan.buffer_start ? 1'b0 : sq_r;
  assign offset_cur = in_chan.buffer_start ? '0 : offset_r;

  // one classifier per byte
  for (genvar g = 0; g < CHUNK_BYTES; g++) begin : g_lane
    mscx_lane u_lane (
      .byte_in (chunk[g*BYTE_W +: BYTE_W]),
      .cls     (cls[g])
    );
  end

  mscx_merge u_merge (
    .cls       (cls),
    .count     (count),
    .dq_in     (dq_cur),
    .sq_in     (sq_cur),
    .emit_mask (emit_mask),
    .dq_out    (dq_end),
    .sq_out    (sq_end)
  );

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid & can_load;

  mscx_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .mask_in  (emit_mask),
    .bytes_in (chunk),
    .base_in  (offset_cur),
    .can_load (can_load),
    .out_ch   (out_chan)
  );

  always_comb begin
    dq_nxt     = dq_r;
    sq_nxt     = sq_r;
    offset_nxt = offset_r;
    if (accept) begin
      dq_nxt     = dq_end;
      sq_nxt     = sq_end;
      offset_nxt = offset_cur + POS_W'(count);   // wraps modulo 2^32
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_r     <= 1'b0;
      sq_r     <= 1'b0;
      offset_r <= '0;
    end else begin
      dq_r     <= dq_nxt;
      sq_r     <= sq_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

>>> hw/rtl/mscx_checker.sv
// ----------------------------------------------------------------------------
// mscx_checker
// port level checks of the structural character indexer
// ----------------------------------------------------------------------------
module mscx_checker
  import mscx_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  out_position,
  input logic [BYTE_W-1:0] out_character,
  input logic              out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_position) && $stable(out_character) && $stable(out_last))
    else $error("result payload changed while stalled");

  // no new chunk while a stalled result is not the last of its chunk
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_last |-> !in_ready)
    else $error("input ready while chunk results still pending");

  // reset leaves no result on the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind markup_structural_char_indexer mscx_checker u_mscx_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_position  (out_chan.position),
  .out_character (out_chan.character),
  .out_last      (out_chan.last_of_chunk)
);

>>> tb/tb_markup_structural_char_indexer.sv
// ----------------------------------------------------------------------------
// tb_markup_structural_char_indexer
// self-checking bench for the structural character indexer: a queue-fed
// driver offers 16-byte chunks of generated markup and noise, a predictor
// tracks quote parities and the byte offset, and a monitor checks every
// result transfer against the oldest predicted hit
// ----------------------------------------------------------------------------
module tb_markup_structural_char_indexer
  import mscx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;   // long output hold-off, fills the block
  localparam int HOLD_AFTER  = 30;    // chunk transfers before the hold-off
  localparam int QUIET_TAIL  = 40;    // last chunks run with no idling
  localparam int RANDOM_CHUNKS = 200;
  localparam int MAX_PRINTS  = 40;

  // one input chunk as the driver offers it
  typedef struct {
    logic [HALF_W-1:0]  bytes_low;
    logic [HALF_W-1:0]  bytes_high;
    logic [COUNT_W-1:0] byte_count;
    logic               buffer_start;
  } chunk_t;

  // one structural hit as the block should report it
  typedef struct {
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] character;
    logic              last_of_chunk;
  } hit_t;

  logic clk;
  logic rst_n;

  mscx_in_if  in_chan ();
  mscx_out_if out_chan ();

  markup_structural_char_indexer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // stimulus and scoreboard storage
  chunk_t pending_chunks[$];
  hit_t   expected_hits[$];
  chunk_t cur_chunk;          // chunk currently on the input channel
  int     total_chunks;
  int     chunks_accepted;
  int     mismatches;
  int     cycle_count;

  // predictor state: quote parities and running byte offset
  logic             dq_inside;
  logic             sq_inside;
  logic [POS_W-1:0] text_offset;

  // idling bookkeeping
  int send_gap;
  int recv_stall;
  int hold_left;
  bit hold_done;

  logic [BYTE_W-1:0] struct_chars[7] = '{CH_LT, CH_GT, CH_SLASH, CH_EQ, CH_AMP,
                                          CH_DQUOTE, CH_SQUOTE};

  // clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // append to the stimulus and scoreboard queues
  function automatic void queue_chunk(chunk_t c);
    pending_chunks = {pending_chunks, c};
  endfunction

  function automatic void queue_hit(hit_t h);
    expected_hits = {expected_hits, h};
  endfunction

  // idling is allowed in bursts of chunk transfers, never in the tail
  function automatic bit idling_allowed(int accepted);
    if (accepted + QUIET_TAIL >= total_chunks)
      return 1'b0;
    return ((accepted / 20) % 4) != 3;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: every accepted chunk turns into zero or more expected hits
  // ---------------------------------------------------------------------------
  function automatic void predict_hits(chunk_t c);
    logic [CHUNK_W-1:0] flat;
    logic [BYTE_W-1:0]  ch;
    int                 n;
    int                 found;
    bit                 is_quote;
    bit                 is_special;
    hit_t               h;

    if (c.buffer_start) begin
      dq_inside   = 1'b0;
      sq_inside   = 1'b0;
      text_offset = '0;
    end
    // counts above the chunk size saturate, zero examines nothing
    n     = (c.byte_count > CHUNK_BYTES) ? CHUNK_BYTES : int'(c.byte_count);
    flat  = {c.bytes_high, c.bytes_low};
    found = 0;
    for (int k = 0; k < n; k++) begin
      ch = flat[k*BYTE_W +: BYTE_W];
      // each quote kind toggles on its own, even inside the other kind
      if (ch == CH_DQUOTE) dq_inside = ~dq_inside;
      if (ch == CH_SQUOTE) sq_inside = ~sq_inside;
      is_quote   = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
      is_special = (ch == CH_LT) || (ch == CH_GT) || (ch == CH_SLASH) ||
                   (ch == CH_EQ) || (ch == CH_AMP);
      if (is_quote || (is_special && !dq_inside && !sq_inside)) begin
        h.position      = text_offset + POS_W'(k);
        h.character     = ch;
        h.last_of_chunk = 1'b0;
        queue_hit(h);
        found++;
      end
    end
    // flag the final hit of this chunk
    if (found > 0)
      expected_hits[expected_hits.size() - 1].last_of_chunk = 1'b1;
    text_offset = text_offset + POS_W'(n);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic string byte_str(logic [BYTE_W-1:0] b);
    string s;
    s    = " ";
    s[0] = b;
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_letter();
    return BYTE_W'(8'h61 + $urandom_range(0, 25));
  endfunction

  // chunk from a slice of text; bytes past the count or the text are random
  function automatic chunk_t chunk_from_text(string s, int from, int cnt, bit start);
    logic [CHUNK_W-1:0] flat;
    chunk_t             c;
    flat = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < CHUNK_BYTES; k++)
      if (k < cnt && from + k < s.len())
        flat[k*BYTE_W +: BYTE_W] = s[from + k];
    c.bytes_low    = flat[HALF_W-1:0];
    c.bytes_high   = flat[CHUNK_W-1:HALF_W];
    c.byte_count   = COUNT_W'(cnt);
    c.buffer_start = start;
    return c;
  endfunction

  // attribute value: text with specials and the other quote kind mixed in
  function automatic string attr_value(logic [BYTE_W-1:0] q);
    string v;
    int    len;
    v   = "";
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++)
      case ($urandom_range(0, 5))
        0:       v = {v, byte_str(struct_chars[$urandom_range(0, 4)])};
        1:       v = {v, byte_str((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE)};
        default: v = {v, byte_str(rand_letter())};
      endcase
    return {byte_str(q), v, byte_str(q)};
  endfunction

  // a small markup document, sometimes broken by a stray quote
  function automatic string build_doc();
    string d;
    string name;
    int    tags;
    d    = "";
    tags = $urandom_range(2, 5);
    for (int t = 0; t < tags; t++) begin
      name = "";
      for (int i = 0; i < $urandom_range(1, 5); i++)
        name = {name, byte_str(rand_letter())};
      d = {d, "<", name};
      for (int a = 0; a < $urandom_range(0, 3); a++)
        d = {d, " ", byte_str(rand_letter()), "=",
             attr_value($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE)};
      d = {d, ($urandom_range(0, 5) == 0) ? "/>" : ">"};
      case ($urandom_range(0, 7))
        0:       d = {d, "a &amp; b"};
        1:       d = {d, "it", byte_str(($urandom_range(0, 1)) ? CH_SQUOTE : CH_DQUOTE), "s"};
        default: d = {d, "text"};
      endcase
      d = {d, "</", name, ">"};
    end
    return d;
  endfunction

  // cut a document into chunks, the first one opening a new buffer
  function automatic void push_doc(string d);
    int p;
    int cnt;
    p = 0;
    while (p < d.len()) begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CHUNK_BYTES) : CHUNK_BYTES;
      if (cnt > d.len() - p)
        cnt = d.len() - p;
      queue_chunk(chunk_from_text(d, p, cnt, p == 0));
      // now and then an empty chunk in the middle of a document
      if ($urandom_range(0, 15) == 0)
        queue_chunk(chunk_from_text("", 0, 0, 1'b0));
      p += cnt;
    end
  endfunction

  // noise chunk: random bytes or a dense mix of structural bytes
  function automatic chunk_t noise_chunk();
    chunk_t c;
    string  s;
    int     cnt;
    s = "";
    for (int k = 0; k < CHUNK_BYTES; k++)
      s = {s, byte_str(($urandom_range(0, 1)) ? struct_chars[$urandom_range(0, 6)]
                                              : BYTE_W'($urandom))};
    case ($urandom_range(0, 9))
      0:       cnt = $urandom_range(17, 31);     // saturating count
      1:       cnt = 0;
      2, 3:    cnt = $urandom_range(1, 15);
      default: cnt = CHUNK_BYTES;
    endcase
    c = chunk_from_text(s, 0, cnt, $urandom_range(0, 15) == 0);
    if ($urandom_range(0, 2) == 0) begin
      c.bytes_low  = {$urandom, $urandom};
      c.bytes_high = {$urandom, $urandom};
    end
    return c;
  endfunction

  function automatic void fill_directed();
    chunk_t c;
    // every special byte once and each quote kind as a closed pair, outside any quote region
    queue_chunk(chunk_from_text("<>/=&ab\"c\"d'e'fg", 0, 16, 1'b1));
    // specials inside double quotes are suppressed, quotes still reported
    queue_chunk(chunk_from_text("a=\"<x>/&=\"<b/>==", 0, 16, 1'b0));
    // double-quote region carried into the next chunk and closed there
    queue_chunk(chunk_from_text("<p x=\"ab</>&=cd", 0, 15, 1'b0));
    queue_chunk(chunk_from_text("<>/=&\"</>&=<<>>/", 0, 16, 1'b0));
    // single-quote region spanning chunks
    queue_chunk(chunk_from_text("q='<&>/", 0, 7, 1'b0));
    queue_chunk(chunk_from_text("=>'<>", 0, 5, 1'b0));
    // each quote kind toggles inside the other kind
    queue_chunk(chunk_from_text("\"'<'\">'\"=\"'&<>/", 0, 16, 1'b0));
    // open a region, then buffer start clears the parity
    queue_chunk(chunk_from_text("\"''\"'\"", 0, 6, 1'b0));
    queue_chunk(chunk_from_text("<a>", 0, 3, 1'b1));
    // empty chunks, with and without buffer start
    queue_chunk(chunk_from_text("<<<<", 0, 0, 1'b0));
    queue_chunk(chunk_from_text("<<<<", 0, 0, 1'b1));
    // counts above the chunk size saturate
    queue_chunk(chunk_from_text("<>/=&\"'<>/=&\"'<>", 0, 17, 1'b0));
    queue_chunk(chunk_from_text("&&&&&&&&&&&&&&&&", 0, 31, 1'b0));
    // a single valid byte, structural bytes beyond the count ignored
    queue_chunk(chunk_from_text("<<<<<<<<<<<<<<<<", 0, 1, 1'b0));
    queue_chunk(chunk_from_text("a<<<<<<<<<<<<<<<", 0, 1, 1'b0));
    // no structural byte at all
    queue_chunk(chunk_from_text("abcdefghijklmnop", 0, 16, 1'b0));
    // all quotes: sixteen hits, parity back to outside
    queue_chunk(chunk_from_text("\"\"\"\"''''\"\"\"\"''''", 0, 16, 1'b0));
    // sixteen specials: the densest chunk
    queue_chunk(chunk_from_text("<>/=&<>/=&<>/=&<", 0, 16, 1'b0));
    // extremes of the data words
    c = '{bytes_low: '1, bytes_high: '1, byte_count: 5'd16, buffer_start: 1'b0};
    queue_chunk(c);
    c = '{bytes_low: '0, bytes_high: '0, byte_count: 5'd16, buffer_start: 1'b0};
    queue_chunk(c);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers chunks from the pending queue, predicts on each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : chunk_driver
    chunk_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap      = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_hits(cur_chunk);
        chunks_accepted <= chunks_accepted + 1;
      end
      // the channel is free when nothing is offered or the offer just moved
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_chunks.size() > 0) begin
          nxt       = pending_chunks.pop_front();
          cur_chunk = nxt;
          in_chan.bytes_low    <= nxt.bytes_low;
          in_chan.bytes_high   <= nxt.bytes_high;
          in_chan.byte_count   <= nxt.byte_count;
          in_chan.buffer_start <= nxt.buffer_start;
          in_chan.valid        <= 1'b1;
          // a gap starts after this chunk has moved
          if (idling_allowed(chunks_accepted) && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 12);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, counted on its own so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chunks_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: ready with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_stall     = 0;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_chan.ready <= 1'b0;
    end else if (idling_allowed(chunks_accepted) && $urandom_range(0, 6) == 0) begin
      recv_stall = $urandom_range(1, 12) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result transfer against the oldest expected hit
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : hit_monitor
    hit_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected hit pos %0d char %02h last %0b",
                                  out_chan.position, out_chan.character,
                                  out_chan.last_of_chunk));
      end else begin
        want = expected_hits.pop_front();
        if (out_chan.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d",
                                    out_chan.position, want.position));
        if (out_chan.character !== want.character)
          report_mismatch($sformatf("char %02h at %0d, want %02h",
                                    out_chan.character, want.position, want.character));
        if (out_chan.last_of_chunk !== want.last_of_chunk)
          report_mismatch($sformatf("last_of_chunk %0b at %0d, want %0b",
                                    out_chan.last_of_chunk, want.position,
                                    want.last_of_chunk));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, load stimulus, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    int random_added;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.bytes_low    = '0;
    in_chan.bytes_high   = '0;
    in_chan.byte_count   = '0;
    in_chan.buffer_start = 1'b0;
    out_chan.ready       = 1'b0;
    cycle_count          = 0;
    chunks_accepted      = 0;
    mismatches           = 0;
    dq_inside            = 1'b0;
    sq_inside            = 1'b0;
    text_offset          = '0;

    fill_directed();
    // mostly well-formed documents, the rest noise
    random_added = 0;
    while (random_added < RANDOM_CHUNKS) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_chunk(noise_chunk());
        random_added++;
      end else begin
        random_added -= pending_chunks.size();
        push_doc(build_doc());
        random_added += pending_chunks.size();
      end
    end
    total_chunks = pending_chunks.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every chunk to move and every hit to come out
    do @(negedge clk);
    while (pending_chunks.size() != 0 || in_chan.valid || expected_hits.size() != 0);
    repeat (50) @(negedge clk);

    if (expected_hits.size() != 0)
      report_mismatch($sformatf("%0d hits never came out", expected_hits.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
